[sv/rrd_pkg.sv]
// ============================================================================
// rrd_pkg - shared types and constants for the RESP2 reply deframer
// Byte codes, event and error codes, the classified-token record passed from
// the front end to the parser, and the result record on the output side.
// ============================================================================
package rrd_pkg;

    localparam int unsigned LENGTH_BITS_DEF = 32;
    localparam int unsigned COUNT_BITS_DEF  = 16;

    localparam int unsigned MAX_LEN_W   = 31;
    localparam int unsigned MAX_ELEM_W  = 16;
    localparam int unsigned CFG_DATA_W  = 31;
    localparam int unsigned ACC_W       = 32;
    localparam int unsigned INDEX_W     = 16;

    localparam logic [MAX_LEN_W-1:0]  MAX_LEN_RST  = 31'd536870912;
    localparam logic [MAX_ELEM_W-1:0] MAX_ELEM_RST = 16'd65535;

    // configuration register indexes
    localparam logic CFG_MAX_LEN  = 1'b0;
    localparam logic CFG_MAX_ELEM = 1'b1;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_END   = 2'd1,
        EV_SKIP  = 2'd2,
        EV_ERROR = 2'd3
    } event_kind_t;

    typedef enum logic [2:0] {
        ERR_LEAD   = 3'd0,
        ERR_DIGITS = 3'd1,
        ERR_CRLF   = 3'd2,
        ERR_NESTED = 3'd3,
        ERR_LIMIT  = 3'd4
    } error_code_t;

    // one received byte with its character class worked out
    typedef struct packed {
        logic [7:0] rx_byte;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_cr;
        logic       is_lf;
        logic       is_star;
        logic       is_dollar;
        logic       is_colon;
        logic       is_plus;
        logic       is_minus;
    } token_t;

    // queue head as seen by the parser
    typedef struct packed {
        logic   valid;
        token_t tok;
    } queue_head_t;

    typedef struct packed {
        event_kind_t        event_kind;
        logic [7:0]         data_byte;
        logic [INDEX_W-1:0] element_index;
        logic               element_null;
        logic               element_is_integer;
        logic               last_of_reply;
        error_code_t        error_code;
    } result_t;

endpackage

[sv/rrd_front.sv]
// ============================================================================
// rrd_front - byte intake and character classifier
// Accepts reply bytes, tags each with its character class and holds them in
// a two-word queue that the parser drains at its own pace.
// ============================================================================
module rrd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] rx_byte
    output rrd_pkg::queue_head_t head,
    input  logic                pop
);
    import rrd_pkg::*;

    token_t     q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    token_t     tok_in;
    logic       push;

    always_comb begin
        tok_in           = '0;
        tok_in.rx_byte   = s_tdata;
        tok_in.is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
        tok_in.digit     = s_tdata[3:0];
        tok_in.is_cr     = (s_tdata == CH_CR);
        tok_in.is_lf     = (s_tdata == CH_LF);
        tok_in.is_star   = (s_tdata == CH_STAR);
        tok_in.is_dollar = (s_tdata == CH_DOLLAR);
        tok_in.is_colon  = (s_tdata == CH_COLON);
        tok_in.is_plus   = (s_tdata == CH_PLUS);
        tok_in.is_minus  = (s_tdata == CH_MINUS);
    end

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head.valid = (count_reg != 2'd0);
    assign head.tok   = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= tok_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count lost a word");

endmodule

[sv/rrd_back.sv]
// ============================================================================
// rrd_back - RESP2 parser and result register
// Walks the reply grammar one classified byte per cycle while the output
// register can load, and loads at most one event per byte into it.
// ============================================================================
module rrd_back #(
    parameter int unsigned LENGTH_BITS = rrd_pkg::LENGTH_BITS_DEF,
    parameter int unsigned COUNT_BITS  = rrd_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rrd_pkg::queue_head_t          head,
    output logic                          pop,
    input  logic [rrd_pkg::MAX_LEN_W-1:0] max_element_len,
    input  logic [rrd_pkg::MAX_ELEM_W-1:0] max_elements,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rrd_pkg::result_t              out_data
);
    import rrd_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_STATUS, PH_STATUS_CR, PH_CNT_FIRST, PH_CNT_DIGITS,
        PH_CNT_CR, PH_ELEM_LEAD, PH_LEN_FIRST, PH_LEN_DIGITS, PH_LEN_CR,
        PH_BULK_DATA, PH_TRAIL1, PH_TRAIL2, PH_INT_LINE, PH_INT_CR
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic [COUNT_BITS-1:0]  left_reg, left_next;
    logic [COUNT_BITS-1:0]  pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] bytes_reg, bytes_next;
    logic [1:0]             flags_reg, flags_next;

    logic                   out_valid_reg;
    result_t                out_data_reg;

    token_t                 tok;
    logic                   can_load;
    logic                   emit;
    result_t                res;
    logic                   do_end;
    logic                   do_fail;
    error_code_t            fail_code;
    logic [ACC_W+3:0]       acc_wide;
    logic [ACC_W-1:0]       acc_step;
    logic [LENGTH_BITS-1:0] bytes_dec;
    logic [COUNT_BITS-1:0]  left_dec;
    logic [INDEX_W-1:0]     pos_idx;
    logic                   count_over;
    logic                   len_over;

    assign tok      = head.tok;
    assign can_load = !out_valid_reg || out_ready;
    assign pop      = head.valid && can_load;
    assign pos_idx  = INDEX_W'(pos_reg);

    // times ten plus digit, saturating at all ones
    always_comb begin
        acc_wide = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1)
                 + {{ACC_W{1'b0}}, tok.digit};
        acc_step = (acc_wide[ACC_W+3:ACC_W] != 4'b0000) ? '1 : acc_wide[ACC_W-1:0];
    end

    assign count_over = (acc_reg > {{(ACC_W-MAX_ELEM_W){1'b0}}, max_elements})
                     || ((acc_reg >> COUNT_BITS) != '0);
    assign len_over   = (acc_reg > {{(ACC_W-MAX_LEN_W){1'b0}}, max_element_len})
                     || ((acc_reg >> LENGTH_BITS) != '0);
    assign bytes_dec  = (bytes_reg != '0) ? bytes_reg - 1'b1 : bytes_reg;
    assign left_dec   = (left_reg != '0) ? left_reg - 1'b1 : left_reg;

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        bytes_next = bytes_reg;
        flags_next = flags_reg;
        emit       = 1'b0;
        res        = '0;
        res.event_kind = EV_DATA;
        res.error_code = ERR_LEAD;
        do_end     = 1'b0;
        do_fail    = 1'b0;
        fail_code  = ERR_LEAD;

        case (phase_reg)
            PH_IDLE: begin
                if (tok.is_star) begin
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    phase_next = PH_CNT_FIRST;
                end else if (tok.is_plus || tok.is_minus) begin
                    phase_next = PH_STATUS;
                end else begin
                    do_fail = 1'b1;
                end
            end
            PH_STATUS: begin
                if (tok.is_cr) begin
                    phase_next = PH_STATUS_CR;
                end
            end
            PH_STATUS_CR: begin
                if (!tok.is_lf) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_CRLF;
                end else begin
                    phase_next     = PH_IDLE;
                    acc_next       = '0;
                    neg_next       = 1'b0;
                    left_next      = '0;
                    pos_next       = '0;
                    bytes_next     = '0;
                    flags_next     = '0;
                    emit           = 1'b1;
                    res.event_kind = EV_SKIP;
                end
            end
            PH_CNT_FIRST, PH_LEN_FIRST: begin
                if (tok.is_minus && !neg_reg) begin
                    neg_next = 1'b1;
                end else if (!tok.is_digit) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_DIGITS;
                end else begin
                    acc_next   = acc_step;
                    phase_next = (phase_reg == PH_CNT_FIRST) ? PH_CNT_DIGITS : PH_LEN_DIGITS;
                end
            end
            PH_CNT_DIGITS, PH_LEN_DIGITS: begin
                if (tok.is_digit) begin
                    acc_next = acc_step;
                end else if (!tok.is_cr) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_DIGITS;
                end else begin
                    phase_next = (phase_reg == PH_CNT_DIGITS) ? PH_CNT_CR : PH_LEN_CR;
                end
            end
            PH_CNT_CR: begin
                if (!tok.is_lf) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_CRLF;
                end else if (neg_reg) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_NESTED;
                end else if (acc_reg == '0) begin
                    // empty array: skip the reply
                    phase_next     = PH_IDLE;
                    acc_next       = '0;
                    neg_next       = 1'b0;
                    left_next      = '0;
                    pos_next       = '0;
                    bytes_next     = '0;
                    flags_next     = '0;
                    emit           = 1'b1;
                    res.event_kind = EV_SKIP;
                end else if (count_over) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_LIMIT;
                end else begin
                    left_next  = acc_reg[COUNT_BITS-1:0];
                    pos_next   = '0;
                    acc_next   = '0;
                    phase_next = PH_ELEM_LEAD;
                end
            end
            PH_ELEM_LEAD: begin
                flags_next = '0;
                acc_next   = '0;
                neg_next   = 1'b0;
                if (tok.is_dollar) begin
                    phase_next = PH_LEN_FIRST;
                end else if (tok.is_colon) begin
                    flags_next = 2'b10;
                    phase_next = PH_INT_LINE;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = tok.is_star ? ERR_NESTED : ERR_LEAD;
                end
            end
            PH_LEN_CR: begin
                if (!tok.is_lf) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_CRLF;
                end else if (neg_reg) begin
                    // only minus one is a null element
                    if (acc_reg != {{(ACC_W-1){1'b0}}, 1'b1}) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_DIGITS;
                    end else begin
                        flags_next = 2'b01;
                        do_end     = 1'b1;
                    end
                end else if (len_over) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_LIMIT;
                end else begin
                    bytes_next = acc_reg[LENGTH_BITS-1:0];
                    acc_next   = '0;
                    phase_next = (acc_reg != '0) ? PH_BULK_DATA : PH_TRAIL1;
                end
            end
            PH_BULK_DATA: begin
                bytes_next        = bytes_dec;
                if (bytes_dec == '0) begin
                    phase_next = PH_TRAIL1;
                end
                emit              = 1'b1;
                res.event_kind    = EV_DATA;
                res.data_byte     = tok.rx_byte;
                res.element_index = pos_idx;
            end
            PH_TRAIL1: begin
                phase_next = PH_TRAIL2;
            end
            PH_TRAIL2: begin
                do_end = 1'b1;
            end
            PH_INT_LINE: begin
                if (tok.is_cr) begin
                    phase_next = PH_INT_CR;
                end else begin
                    emit                   = 1'b1;
                    res.event_kind         = EV_DATA;
                    res.data_byte          = tok.rx_byte;
                    res.element_index      = pos_idx;
                    res.element_is_integer = 1'b1;
                end
            end
            PH_INT_CR: begin
                if (!tok.is_lf) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_CRLF;
                end else begin
                    do_end = 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                acc_next   = '0;
                neg_next   = 1'b0;
                left_next  = '0;
                pos_next   = '0;
                bytes_next = '0;
                flags_next = '0;
            end
        endcase

        if (do_end) begin
            emit                   = 1'b1;
            res                    = '0;
            res.event_kind         = EV_END;
            res.error_code         = ERR_LEAD;
            res.element_index      = pos_idx;
            res.element_null       = flags_next[0];
            res.element_is_integer = flags_next[1];
            res.last_of_reply      = (left_reg <= {{(COUNT_BITS-1){1'b0}}, 1'b1});
            left_next  = left_dec;
            flags_next = '0;
            acc_next   = '0;
            neg_next   = 1'b0;
            bytes_next = '0;
            if (left_dec == '0) begin
                pos_next   = '0;
                phase_next = PH_IDLE;
            end else begin
                pos_next   = pos_reg + 1'b1;
                phase_next = PH_ELEM_LEAD;
            end
        end

        if (do_fail) begin
            emit           = 1'b1;
            res            = '0;
            res.event_kind = EV_ERROR;
            res.error_code = fail_code;
            phase_next     = PH_IDLE;
            acc_next       = '0;
            neg_next       = 1'b0;
            left_next      = '0;
            pos_next       = '0;
            bytes_next     = '0;
            flags_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            left_reg      <= '0;
            pos_reg       <= '0;
            bytes_reg     <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                left_reg  <= left_next;
                pos_reg   <= pos_next;
                bytes_reg <= bytes_next;
                flags_reg <= flags_next;
            end
            if (can_load) begin
                out_valid_reg <= pop && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_bulk_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BULK_DATA |-> bytes_reg != '0)
        else $error("bulk data phase with no bytes left");

    a_elems_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ELEM_LEAD || phase_reg == PH_TRAIL2 || phase_reg == PH_INT_CR)
        |-> left_reg != '0)
        else $error("element phase with no elements left");

    a_data_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && emit && res.event_kind == EV_DATA)
        |-> (phase_reg == PH_BULK_DATA || phase_reg == PH_INT_LINE))
        else $error("data word outside a payload phase");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> (left_reg == '0 && pos_reg == '0))
        else $error("idle parser holds array state");

endmodule

[sv/resp_reply_deframer.sv]
// ============================================================================
// resp_reply_deframer - RESP2 array reply deframer
// Splits a byte stream of server replies into element payload words and
// element-end, skip and error events.
// ============================================================================
// Usage:
//   s_ channel: one reply byte per word in s_tdata.
//   m_ channel: one event per word; m_tuser is the event kind, m_tlast marks
//     the element end that closes an array reply.
//   cfg_we/cfg_addr/cfg_wdata: length and count limits, written while idle.
// Each byte passes the queue and the parser; its event is registered for m_.
// Throughput: one byte per cycle while m_tready is high; the parser retires
//   one queued byte per cycle and emits at most one event for it.
// A two-word queue sits between the classifier and the parser, and the
//   event register holds its word while m_tready is low; s_tready drops only
//   once the queue is full.
// Reset (aresetn low, synchronous) empties the queue and output register,
//   returns the parser to waiting for a reply lead byte and restores the
//   default limits.
// Bad input, bulk trailers aside, yields one error event and a restart at idle.
// ============================================================================
module resp_reply_deframer #(
    parameter int unsigned LENGTH_BITS = rrd_pkg::LENGTH_BITS_DEF,
    parameter int unsigned COUNT_BITS  = rrd_pkg::COUNT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] data_byte, [23:8] element_index, [24] element_null,
    // [25] element_is_integer, [28:26] error_code, [31:29] zero
    output logic [31:0]                    m_tdata,
    output logic [1:0]                     m_tuser,   // [1:0] event_kind
    output logic                           m_tlast,   // last_of_reply
    input  logic                           cfg_we,
    input  logic                           cfg_addr,
    input  logic [rrd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rrd_pkg::*;

    logic [MAX_LEN_W-1:0]  max_len_reg;
    logic [MAX_ELEM_W-1:0] max_elem_reg;
    queue_head_t           head;
    logic                  pop;
    result_t               res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg  <= MAX_LEN_RST;
            max_elem_reg <= MAX_ELEM_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_MAX_LEN:  max_len_reg  <= cfg_wdata[MAX_LEN_W-1:0];
                CFG_MAX_ELEM: max_elem_reg <= cfg_wdata[MAX_ELEM_W-1:0];
                default:      max_len_reg  <= max_len_reg;
            endcase
        end
    end

    rrd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    rrd_back #(
        .LENGTH_BITS (LENGTH_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (head),
        .pop             (pop),
        .max_element_len (max_len_reg),
        .max_elements    (max_elem_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_data        (res)
    );

    assign m_tdata = {3'b000, res.error_code, res.element_is_integer,
                      res.element_null, res.element_index, res.data_byte};
    assign m_tuser = res.event_kind;
    assign m_tlast = res.last_of_reply;

endmodule
